[rtl/otsu_pkg.sv]
// ----------------------------------------------------------------------------
// otsu_pkg
// Shared types and codes for the Otsu threshold binarizer.
// ----------------------------------------------------------------------------
package otsu_pkg;

    localparam int PIX_W = 8;

    localparam logic ACT_ACCUM    = 1'b0;
    localparam logic ACT_BINARIZE = 1'b1;

    localparam logic KIND_THRESH = 1'b0;
    localparam logic KIND_PIXEL  = 1'b1;

    // Request from the controller to the histogram memory.
    typedef struct packed {
        logic             acc_valid;
        logic [PIX_W-1:0] acc_bin;
        logic             scan_en;
        logic [PIX_W-1:0] scan_addr;
    } hist_req_t;

endpackage

[rtl/otsu_threshold_binarizer_unit.sv]
// ----------------------------------------------------------------------------
// otsu_threshold_binarizer_unit
// Otsu histogram threshold search and pixel binarizer.
// ----------------------------------------------------------------------------
// Accumulate requests are taken one per cycle while not busy and while fewer
// than MAX_FRAME_PIXELS pixels are counted; a binarize result is registered
// and appears in the cycle after its request. A frame_last request holds busy
// for the search, longer for each split with a nonzero score because of the
// bit-serial score multipliers. Results cannot be stalled. Reset zeroes the
// held threshold, sets positive polarity and holds busy during histogram clear.
module otsu_threshold_binarizer_unit #(
    parameter int GRAY_LEVELS      = 256,
    parameter int MAX_FRAME_PIXELS = 1048576
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  logic       action,
    input  logic [7:0] pixel,
    input  logic       frame_last,
    input  logic       cfg_we,
    input  logic       cfg_wdata,
    output logic       result_valid,
    output logic       kind,
    output logic [7:0] threshold,
    output logic       binary_pixel
);
    import otsu_pkg::*;

    localparam int GW  = $clog2(GRAY_LEVELS);
    localparam int CW  = $clog2(MAX_FRAME_PIXELS + 1);
    localparam int SW  = CW + PIX_W;
    localparam int DW  = SW + CW;
    localparam int PW  = 2 * CW;
    localparam int DDW = 2 * DW;
    localparam int SCW = DDW + PW;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_WAIT = 3'd1;
    localparam logic [2:0] S_RD   = 3'd2;
    localparam logic [2:0] S_ADD  = 3'd3;
    localparam logic [2:0] S_MUL  = 3'd4;
    localparam logic [2:0] S_DIFF = 3'd5;
    localparam logic [2:0] S_DD   = 3'd6;
    localparam logic [2:0] S_CMP  = 3'd7;

    logic [2:0]       state_reg, state_next;
    logic             pol_reg;
    logic [7:0]       held_reg;
    logic [CW-1:0]    count_reg;
    logic [SW-1:0]    sum_reg;
    logic [GW-1:0]    j_reg;
    logic [CW-1:0]    n2_reg;
    logic [SW-1:0]    s2_reg;
    logic [DW-1:0]    a_reg, b_reg;
    logic [PW-1:0]    p_reg;
    logic             skip_reg;
    logic             have_reg;
    logic [DDW-1:0]   best_dd_reg;
    logic [PW-1:0]    best_p_reg;
    logic [GW-1:0]    best_t_reg;
    logic             rv_reg, kind_reg, bin_reg;
    logic [7:0]       thr_reg;

    hist_req_t        hreq;
    logic [CW-1:0]    rd_data;
    logic             hist_clearing;
    logic             accept, acc_take;
    logic [GW-1:0]    pix_bin;
    logic [CW-1:0]    n1;
    logic [SW-1:0]    s1;
    logic [DW-1:0]    diff;
    logic             last_bin;
    logic             dd_start, cmp_start;
    logic             dd_run, lhs_run, rhs_run;
    logic [DDW-1:0]   dd;
    logic [SCW-1:0]   lhs, rhs;

    assign accept   = start && !busy;
    assign acc_take = accept && (action == ACT_ACCUM)
                      && (count_reg < CW'(MAX_FRAME_PIXELS));
    assign pix_bin  = ({1'b0, pixel} >= 9'(GRAY_LEVELS - 1))
                      ? GW'(GRAY_LEVELS - 1) : pixel[GW-1:0];
    assign n1       = count_reg - n2_reg;
    assign s1       = sum_reg - s2_reg;
    assign diff     = (a_reg > b_reg) ? (a_reg - b_reg) : (b_reg - a_reg);
    assign last_bin = (j_reg == GW'(GRAY_LEVELS - 1));
    assign busy     = (state_reg != S_IDLE) || hist_clearing;

    always_comb
    begin
        hreq           = '0;
        hreq.acc_valid = acc_take;
        hreq.acc_bin   = PIX_W'(pix_bin);
        hreq.scan_en   = (state_reg == S_RD);
        hreq.scan_addr = PIX_W'(j_reg);
    end

    otsu_hist #(.GRAY_LEVELS(GRAY_LEVELS), .CW(CW)) u_hist (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (hreq),
        .clearing (hist_clearing),
        .rd_data  (rd_data)
    );

    assign dd_start  = (state_reg == S_DIFF) && !skip_reg && (a_reg != b_reg);
    assign cmp_start = (state_reg == S_DD) && !dd_run && have_reg;

    otsu_smul #(.AW(DW), .BW(DW)) u_dd (
        .clk (clk), .rst_n (rst_n), .start (dd_start),
        .a (diff), .b (diff), .running (dd_run), .product (dd)
    );

    otsu_smul #(.AW(DDW), .BW(PW)) u_lhs (
        .clk (clk), .rst_n (rst_n), .start (cmp_start),
        .a (dd), .b (best_p_reg), .running (lhs_run), .product (lhs)
    );

    otsu_smul #(.AW(DDW), .BW(PW)) u_rhs (
        .clk (clk), .rst_n (rst_n), .start (cmp_start),
        .a (best_dd_reg), .b (p_reg), .running (rhs_run), .product (rhs)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept && (action == ACT_ACCUM) && frame_last)
                begin
                    state_next = S_WAIT;
                end
            end
            S_WAIT: state_next = S_RD;
            S_RD:   state_next = S_ADD;
            S_ADD:  state_next = last_bin ? S_IDLE : S_MUL;
            S_MUL:  state_next = S_DIFF;
            S_DIFF: state_next = dd_start ? S_DD : S_RD;
            S_DD:
            begin
                if (!dd_run)
                begin
                    state_next = have_reg ? S_CMP : S_RD;
                end
            end
            S_CMP:
            begin
                if (!lhs_run && !rhs_run)
                begin
                    state_next = S_RD;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_MUL:
            begin
                a_reg    <= DW'(s1 * n2_reg);
                b_reg    <= DW'(s2_reg * n1);
                p_reg    <= PW'(n1 * n2_reg);
                skip_reg <= (n1 == '0) || (n2_reg == '0);
            end
            S_DD:
            begin
                if (!dd_run && !have_reg)
                begin
                    best_dd_reg <= dd;
                    best_p_reg  <= p_reg;
                end
            end
            S_CMP:
            begin
                if (!lhs_run && !rhs_run && (lhs > rhs))
                begin
                    best_dd_reg <= dd;
                    best_p_reg  <= p_reg;
                end
            end
            default: ;
        endcase
        kind_reg <= (state_reg == S_IDLE) ? KIND_PIXEL : KIND_THRESH;
        thr_reg  <= (state_reg == S_IDLE) ? held_reg : 8'(best_t_reg);
        bin_reg  <= (state_reg == S_IDLE) && (pol_reg ? (pixel > held_reg)
                                                      : (pixel < held_reg));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            pol_reg    <= 1'b1;
            held_reg   <= '0;
            count_reg  <= '0;
            sum_reg    <= '0;
            j_reg      <= '0;
            n2_reg     <= '0;
            s2_reg     <= '0;
            have_reg   <= 1'b0;
            best_t_reg <= '0;
            rv_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                pol_reg <= cfg_wdata;
            end
            rv_reg <= 1'b0;
            if (accept && (action == ACT_BINARIZE))
            begin
                rv_reg <= 1'b1;
            end
            if (acc_take)
            begin
                count_reg <= count_reg + CW'(1);
                sum_reg   <= sum_reg + SW'(pix_bin);
            end
            case (state_reg)
                S_ADD:
                begin
                    n2_reg <= n2_reg + rd_data;
                    s2_reg <= s2_reg + SW'(rd_data * j_reg);
                    if (last_bin)
                    begin
                        rv_reg     <= 1'b1;
                        held_reg   <= 8'(best_t_reg);
                        count_reg  <= '0;
                        sum_reg    <= '0;
                        j_reg      <= '0;
                        n2_reg     <= '0;
                        s2_reg     <= '0;
                        have_reg   <= 1'b0;
                        best_t_reg <= '0;
                    end
                end
                S_DIFF:
                begin
                    if (!dd_start)
                    begin
                        j_reg <= j_reg + GW'(1);
                    end
                end
                S_DD:
                begin
                    if (!dd_run && !have_reg)
                    begin
                        have_reg   <= 1'b1;
                        best_t_reg <= j_reg + GW'(1);
                        j_reg      <= j_reg + GW'(1);
                    end
                end
                S_CMP:
                begin
                    if (!lhs_run && !rhs_run)
                    begin
                        if (lhs > rhs)
                        begin
                            best_t_reg <= j_reg + GW'(1);
                        end
                        j_reg <= j_reg + GW'(1);
                    end
                end
                default: ;
            endcase
        end
    end

    assign result_valid = rv_reg;
    assign kind         = kind_reg;
    assign threshold    = thr_reg;
    assign binary_pixel = bin_reg;

endmodule

[rtl/otsu_hist.sv]
// ----------------------------------------------------------------------------
// otsu_hist
// Histogram memory with read-modify-write increment and scan/clear port.
// ----------------------------------------------------------------------------
module otsu_hist #(
    parameter int GRAY_LEVELS = 256,
    parameter int CW          = 21
) (
    input  logic               clk,
    input  logic               rst_n,
    input  otsu_pkg::hist_req_t req,
    output logic               clearing,
    output logic [CW-1:0]      rd_data
);
    import otsu_pkg::*;

    localparam int GW = $clog2(GRAY_LEVELS);

    logic [CW-1:0] mem [GRAY_LEVELS];
    logic [CW-1:0] rdata_reg;

    logic          s1_valid_reg;
    logic [GW-1:0] s1_bin_reg;
    logic          wr_valid_reg;
    logic [GW-1:0] wr_addr_reg;
    logic [CW-1:0] wr_data_reg;
    logic          clr_active_reg;
    logic [GW-1:0] clr_addr_reg;

    logic [GW-1:0] raddr;
    logic [CW-1:0] cur;
    logic [CW-1:0] inc;

    assign raddr = req.acc_valid ? req.acc_bin[GW-1:0] : req.scan_addr[GW-1:0];

    // The previous increment is written at the edge where this one was read,
    // so the read data misses it and it is forwarded here.
    assign cur = (wr_valid_reg && (wr_addr_reg == s1_bin_reg)) ? wr_data_reg : rdata_reg;
    assign inc = cur + CW'(1);

    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
        if (clr_active_reg)
        begin
            mem[clr_addr_reg] <= '0;
        end
        else if (s1_valid_reg)
        begin
            mem[s1_bin_reg] <= inc;
        end
        else if (req.scan_en)
        begin
            mem[req.scan_addr[GW-1:0]] <= '0;
        end
        s1_bin_reg  <= req.acc_bin[GW-1:0];
        wr_addr_reg <= s1_bin_reg;
        wr_data_reg <= inc;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            wr_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= req.acc_valid;
            wr_valid_reg <= s1_valid_reg;
        end
    end

    // After reset every bin is zeroed once, one entry per cycle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
        end
        else if (clr_active_reg)
        begin
            if (clr_addr_reg == GW'(GRAY_LEVELS - 1))
            begin
                clr_active_reg <= 1'b0;
            end
            clr_addr_reg <= clr_addr_reg + GW'(1);
        end
    end

    assign clearing = clr_active_reg;
    assign rd_data  = rdata_reg;

endmodule

[rtl/otsu_smul.sv]
// ----------------------------------------------------------------------------
// otsu_smul
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module otsu_smul #(
    parameter int AW = 50,
    parameter int BW = 50
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [AW-1:0]    a,
    input  logic [BW-1:0]    b,
    output logic             running,
    output logic [AW+BW-1:0] product
);
    import otsu_pkg::*;

    logic             running_reg;
    logic [AW+BW-1:0] acc_reg;
    logic [AW+BW-1:0] a_sh_reg;
    logic [BW-1:0]    b_sh_reg;

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            acc_reg  <= '0;
            a_sh_reg <= (AW+BW)'(a);
            b_sh_reg <= b;
        end
        else if (running_reg)
        begin
            if (b_sh_reg[0])
            begin
                acc_reg <= acc_reg + a_sh_reg;
            end
            a_sh_reg <= a_sh_reg << 1;
            b_sh_reg <= b_sh_reg >> 1;
        end
    end

    // Stops as soon as no multiplier bits remain.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_reg <= 1'b0;
        end
        else if (start)
        begin
            running_reg <= 1'b1;
        end
        else if (running_reg && (b_sh_reg == '0))
        begin
            running_reg <= 1'b0;
        end
    end

    assign running = running_reg;
    assign product = acc_reg;

endmodule

[rtl/otsu_checker.sv]
// ----------------------------------------------------------------------------
// otsu_checker
// Port-level checks for the Otsu threshold binarizer.
// ----------------------------------------------------------------------------
module otsu_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       start,
    input logic       busy,
    input logic       action,
    input logic [7:0] pixel,
    input logic       frame_last,
    input logic       result_valid,
    input logic       kind,
    input logic [7:0] threshold,
    input logic       binary_pixel
);
    import otsu_pkg::*;

    a_bin_result: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (action == ACT_BINARIZE)) |=> (result_valid && (kind == KIND_PIXEL)))
        else $error("binarize request without pixel result");

    a_acc_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (action == ACT_ACCUM) && !frame_last) |=> !result_valid)
        else $error("result after plain accumulate request");

    a_last_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (action == ACT_ACCUM) && frame_last) |=> busy)
        else $error("search did not start");

    a_thr_done: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && (kind == KIND_THRESH)) |-> (!busy && !binary_pixel && $past(busy)))
        else $error("threshold result malformed");

endmodule

bind otsu_threshold_binarizer_unit otsu_checker u_otsu_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .action       (action),
    .pixel        (pixel),
    .frame_last   (frame_last),
    .result_valid (result_valid),
    .kind         (kind),
    .threshold    (threshold),
    .binary_pixel (binary_pixel)
);
